// ===== design/barycentric_triangle_weights_core_defines.svh =====
`ifndef BARYCENTRIC_TRIANGLE_WEIGHTS_CORE_DEFINES_SVH
`define BARYCENTRIC_TRIANGLE_WEIGHTS_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BTW_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("%m: assertion failed");
`define BTW_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("%m: forbidden condition");
`else
`define BTW_ASSERT(lbl, clk, rstn, prop)
`define BTW_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== design/btw_pkg.sv =====
package btw_pkg;

	localparam int DIM_W = 2;
	localparam logic [DIM_W-1:0] MODE_2D = 2'd2;
	localparam logic [DIM_W-1:0] MODE_3D = 2'd3;

	localparam int RES_W = 32;
	localparam int QUO_W = RES_W + 1;
	localparam logic [QUO_W-1:0] RES_POS_LIM = 33'h0_7FFF_FFFF;
	localparam logic [QUO_W-1:0] RES_NEG_LIM = 33'h0_8000_0000;
	localparam logic [RES_W-1:0] RES_MAX = 32'h7FFF_FFFF;
	localparam logic [RES_W-1:0] RES_MIN = 32'h8000_0000;

	localparam int FRONT_LAT = 7;
	localparam int DIV_LAT = QUO_W + 2;

endpackage

// ===== design/btw_front.sv =====
module btw_front #(
	parameter int CW = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            mode_2d,
	input  logic signed [CW-1:0]            ax,
	input  logic signed [CW-1:0]            ay,
	input  logic signed [CW-1:0]            az,
	input  logic signed [CW-1:0]            bx,
	input  logic signed [CW-1:0]            by,
	input  logic signed [CW-1:0]            bz,
	input  logic signed [CW-1:0]            cx,
	input  logic signed [CW-1:0]            cy,
	input  logic signed [CW-1:0]            cz,
	input  logic signed [CW-1:0]            ux,
	input  logic signed [CW-1:0]            uy,
	input  logic signed [CW-1:0]            uz,
	output logic                            out_valid,
	output logic                            out_deg,
	output logic [2*(2*(CW+1)+1)+3:0]       mag_a,
	output logic [2*(2*(CW+1)+1)+3:0]       mag_b,
	output logic [2*(2*(CW+1)+1)+3:0]       mag_c,
	output logic [2*(2*(CW+1)+1)+3:0]       mag_d,
	output logic                            neg_a,
	output logic                            neg_b,
	output logic                            neg_c
);
	import btw_pkg::*;

	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;
	localparam int QW = 2 * XW;
	localparam int NW = QW + 4;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic m2_s1, m2_s2, m2_s3, m2_s4, m2_s5;

	// ab, ac, au (u - a) per axis; bu, cu only for 2D
	logic signed [DW-1:0] ab_s1 [3];
	logic signed [DW-1:0] ac_s1 [3];
	logic signed [DW-1:0] au_s1 [3];
	logic signed [DW-1:0] bu_s1 [2];
	logic signed [DW-1:0] cu_s1 [2];
	logic signed [PW-1:0] p_s2 [18];
	logic signed [XW-1:0] x_s3 [9];
	logic signed [QW-1:0] q_s4 [9];
	logic signed [XW-1:0] k_s4 [3];
	logic signed [NW-1:0] den_s5, f0_s5, f1_s5;
	logic signed [NW-1:0] den_s6, na_s6, nb_s6, nc_s6;
	logic [NW-1:0] ma_s7, mb_s7, mc_s7, md_s7;
	logic na_s7, nb_s7, nc_s7, dg_s7;

	logic signed [DW-1:0] opa [4];
	logic signed [DW-1:0] opb [4];
	logic signed [NW-1:0] miss;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		m2_s1 <= mode_2d;
		ab_s1[0] <= DW'(bx) - DW'(ax);
		ab_s1[1] <= DW'(by) - DW'(ay);
		ab_s1[2] <= DW'(bz) - DW'(az);
		ac_s1[0] <= DW'(cx) - DW'(ax);
		ac_s1[1] <= DW'(cy) - DW'(ay);
		ac_s1[2] <= DW'(cz) - DW'(az);
		au_s1[0] <= DW'(ux) - DW'(ax);
		au_s1[1] <= DW'(uy) - DW'(ay);
		au_s1[2] <= DW'(uz) - DW'(az);
		bu_s1[0] <= DW'(bx) - DW'(ux);
		bu_s1[1] <= DW'(by) - DW'(uy);
		cu_s1[0] <= DW'(cx) - DW'(ux);
		cu_s1[1] <= DW'(cy) - DW'(uy);
	end

	// first four multipliers are shared with the 2D cross products
	always_comb begin
		if (m2_s1) begin
			opa[0] = bu_s1[0]; opb[0] = cu_s1[1];
			opa[1] = bu_s1[1]; opb[1] = cu_s1[0];
			opa[2] = cu_s1[1]; opb[2] = au_s1[0];
			opa[3] = cu_s1[0]; opb[3] = au_s1[1];
		end else begin
			opa[0] = ab_s1[1]; opb[0] = ac_s1[2];
			opa[1] = ab_s1[2]; opb[1] = ac_s1[1];
			opa[2] = ab_s1[2]; opb[2] = ac_s1[0];
			opa[3] = ab_s1[0]; opb[3] = ac_s1[2];
		end
	end

	always_ff @(posedge clk) begin
		m2_s2 <= m2_s1;
		p_s2[0]  <= opa[0] * opb[0];
		p_s2[1]  <= opa[1] * opb[1];
		p_s2[2]  <= opa[2] * opb[2];
		p_s2[3]  <= opa[3] * opb[3];
		p_s2[4]  <= ab_s1[0] * ac_s1[1];
		p_s2[5]  <= ab_s1[1] * ac_s1[0];
		p_s2[6]  <= ab_s1[1] * au_s1[2];
		p_s2[7]  <= ab_s1[2] * au_s1[1];
		p_s2[8]  <= ab_s1[2] * au_s1[0];
		p_s2[9]  <= ab_s1[0] * au_s1[2];
		p_s2[10] <= ab_s1[0] * au_s1[1];
		p_s2[11] <= ab_s1[1] * au_s1[0];
		p_s2[12] <= au_s1[1] * ac_s1[2];
		p_s2[13] <= au_s1[2] * ac_s1[1];
		p_s2[14] <= au_s1[2] * ac_s1[0];
		p_s2[15] <= au_s1[0] * ac_s1[2];
		p_s2[16] <= au_s1[0] * ac_s1[1];
		p_s2[17] <= au_s1[1] * ac_s1[0];
	end

	// 3D: x0..2 = n, x3..5 = ab x au, x6..8 = au x ac
	// 2D: x0 = ka, x1 = kb, x2 = twice the area
	always_ff @(posedge clk) begin
		m2_s3 <= m2_s2;
		for (int i = 0; i < 9; i++) begin
			x_s3[i] <= XW'(p_s2[2*i]) - XW'(p_s2[2*i+1]);
		end
	end

	always_ff @(posedge clk) begin
		m2_s4 <= m2_s3;
		for (int i = 0; i < 3; i++) begin
			q_s4[i]   <= x_s3[i] * x_s3[i];
			q_s4[3+i] <= x_s3[i] * x_s3[3+i];
			q_s4[6+i] <= x_s3[i] * x_s3[6+i];
			k_s4[i]   <= x_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		m2_s5 <= m2_s4;
		if (m2_s4) begin
			den_s5 <= NW'(k_s4[2]);
			f0_s5 <= NW'(k_s4[0]);
			f1_s5 <= NW'(k_s4[1]);
		end else begin
			den_s5 <= NW'(q_s4[0]) + NW'(q_s4[1]) + NW'(q_s4[2]);
			f0_s5 <= NW'(q_s4[6]) + NW'(q_s4[7]) + NW'(q_s4[8]);
			f1_s5 <= NW'(q_s4[3]) + NW'(q_s4[4]) + NW'(q_s4[5]);
		end
	end

	assign miss = den_s5 - f0_s5 - f1_s5;

	always_ff @(posedge clk) begin
		den_s6 <= den_s5;
		if (m2_s5) begin
			na_s6 <= f0_s5;
			nb_s6 <= f1_s5;
			nc_s6 <= miss;
		end else begin
			na_s6 <= miss;
			nb_s6 <= f0_s5;
			nc_s6 <= f1_s5;
		end
	end

	always_ff @(posedge clk) begin
		ma_s7 <= na_s6[NW-1] ? NW'(-na_s6) : NW'(na_s6);
		mb_s7 <= nb_s6[NW-1] ? NW'(-nb_s6) : NW'(nb_s6);
		mc_s7 <= nc_s6[NW-1] ? NW'(-nc_s6) : NW'(nc_s6);
		md_s7 <= den_s6[NW-1] ? NW'(-den_s6) : NW'(den_s6);
		na_s7 <= na_s6[NW-1] ^ den_s6[NW-1];
		nb_s7 <= nb_s6[NW-1] ^ den_s6[NW-1];
		nc_s7 <= nc_s6[NW-1] ^ den_s6[NW-1];
		dg_s7 <= (den_s6 == '0);
	end

	assign out_valid = v_s7;
	assign out_deg = dg_s7;
	assign mag_a = ma_s7;
	assign mag_b = mb_s7;
	assign mag_c = mc_s7;
	assign mag_d = md_s7;
	assign neg_a = na_s7;
	assign neg_b = nb_s7;
	assign neg_c = nc_s7;

endmodule

// ===== design/btw_div.sv =====
module btw_div #(
	parameter int NW = 74,
	parameter int FB = 24
) (
	input  logic                        clk,
	input  logic [NW-1:0]               num,
	input  logic [NW-1:0]               den,
	input  logic                        neg,
	output logic [btw_pkg::RES_W-1:0]   res
);
	import btw_pkg::*;

	localparam int RW = NW + 1;
	localparam int SH = RES_W - FB;

	// one quotient bit per stage, one extra bit below the LSB for rounding
	logic [RW-1:0]    rem_s [QUO_W+1];
	logic [QUO_W-1:0] lo_s  [QUO_W+1];
	logic [QUO_W-1:0] q_s   [QUO_W+1];
	logic [NW-1:0]    d_s   [QUO_W+1];
	logic             neg_s [QUO_W+1];
	logic             sat_s [QUO_W+1];

	logic [NW-1:0]    num_hi;
	logic [QUO_W:0]   qp1;
	logic [QUO_W-1:0] mag;

	assign num_hi = num >> SH;

	always_ff @(posedge clk) begin
		rem_s[0] <= RW'(num_hi);
		lo_s[0] <= QUO_W'(num << (FB + 1));
		q_s[0] <= '0;
		d_s[0] <= den;
		neg_s[0] <= neg;
		sat_s[0] <= (num_hi >= den);
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
		logic [RW-1:0] trial;
		logic          take;
		assign trial = {rem_s[k-1][RW-2:0], lo_s[k-1][QUO_W-1]};
		assign take = (trial >= {1'b0, d_s[k-1]});
		always_ff @(posedge clk) begin
			rem_s[k] <= take ? trial - {1'b0, d_s[k-1]} : trial;
			lo_s[k] <= {lo_s[k-1][QUO_W-2:0], 1'b0};
			q_s[k] <= {q_s[k-1][QUO_W-2:0], take};
			d_s[k] <= d_s[k-1];
			neg_s[k] <= neg_s[k-1];
			sat_s[k] <= sat_s[k-1];
		end
	end

	assign qp1 = {1'b0, q_s[QUO_W]} + (QUO_W+1)'(1);
	assign mag = sat_s[QUO_W] ? {1'b1, {RES_W{1'b0}}} : qp1[QUO_W:1];

	always_ff @(posedge clk) begin
		if (!neg_s[QUO_W]) begin
			res <= (mag > RES_POS_LIM) ? RES_MAX : mag[RES_W-1:0];
		end else begin
			res <= (mag > RES_NEG_LIM) ? RES_MIN : RES_W'(-mag);
		end
	end

endmodule

// ===== design/barycentric_triangle_weights_core.sv =====
// Barycentric weights of a point with respect to a triangle.
// Command side: drive corners and point with start high; busy is always low,
// so a new item may be issued on every clock.
// Result side: done pulses for one cycle with weight_a/b/c (Q.24, saturated)
// and degenerate_flag. Results leave in issue order; the receiver cannot
// stall, and none is needed because the pipeline never backs up.
// Throughput is one item per cycle. The depth is set by the two multiply
// levels of the geometry front end (7 stages) and the three parallel
// bit-per-stage dividers (35 stages incl. input and rounding registers),
// plus the output register.
// Config: cfg_valid/cfg_ready/cfg_data sets dimension_mode (2 = 2D, else 3D);
// cfg_ready is always high. Write it only while no item is in flight.
// Reset: arst_n clears all valid bits and sets dimension_mode to 3.
// A zero-area triangle gives zero weights with degenerate_flag set.
`include "barycentric_triangle_weights_core_defines.svh"

module barycentric_triangle_weights_core #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [COORD_BITS-1:0]     corner_a_x,
	input  logic signed [COORD_BITS-1:0]     corner_a_y,
	input  logic signed [COORD_BITS-1:0]     corner_a_z,
	input  logic signed [COORD_BITS-1:0]     corner_b_x,
	input  logic signed [COORD_BITS-1:0]     corner_b_y,
	input  logic signed [COORD_BITS-1:0]     corner_b_z,
	input  logic signed [COORD_BITS-1:0]     corner_c_x,
	input  logic signed [COORD_BITS-1:0]     corner_c_y,
	input  logic signed [COORD_BITS-1:0]     corner_c_z,
	input  logic signed [COORD_BITS-1:0]     point_x,
	input  logic signed [COORD_BITS-1:0]     point_y,
	input  logic signed [COORD_BITS-1:0]     point_z,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [btw_pkg::DIM_W-1:0]        cfg_data,
	output logic                             done,
	output logic signed [btw_pkg::RES_W-1:0] weight_a,
	output logic signed [btw_pkg::RES_W-1:0] weight_b,
	output logic signed [btw_pkg::RES_W-1:0] weight_c,
	output logic                             degenerate_flag
);
	import btw_pkg::*;

	localparam int NW = 2 * (2 * (COORD_BITS + 1) + 1) + 4;

	logic [DIM_W-1:0] mode_q;
	logic             f_valid, f_deg;
	logic [NW-1:0]    f_ma, f_mb, f_mc, f_md;
	logic             f_na, f_nb, f_nc;
	logic [RES_W-1:0] r_a, r_b, r_c;
	logic             v_pipe_q [DIV_LAT];
	logic             d_pipe_q [DIV_LAT];
	logic             done_q, deg_q;
	logic [RES_W-1:0] wa_q, wb_q, wc_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_3D;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	btw_front #(.CW(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(start && !busy), .mode_2d(mode_q == MODE_2D),
		.ax(corner_a_x), .ay(corner_a_y), .az(corner_a_z),
		.bx(corner_b_x), .by(corner_b_y), .bz(corner_b_z),
		.cx(corner_c_x), .cy(corner_c_y), .cz(corner_c_z),
		.ux(point_x), .uy(point_y), .uz(point_z),
		.out_valid(f_valid), .out_deg(f_deg),
		.mag_a(f_ma), .mag_b(f_mb), .mag_c(f_mc), .mag_d(f_md),
		.neg_a(f_na), .neg_b(f_nb), .neg_c(f_nc)
	);

	btw_div #(.NW(NW), .FB(FRAC_BITS)) u_div_a (
		.clk(clk), .num(f_ma), .den(f_md), .neg(f_na), .res(r_a)
	);
	btw_div #(.NW(NW), .FB(FRAC_BITS)) u_div_b (
		.clk(clk), .num(f_mb), .den(f_md), .neg(f_nb), .res(r_b)
	);
	btw_div #(.NW(NW), .FB(FRAC_BITS)) u_div_c (
		.clk(clk), .num(f_mc), .den(f_md), .neg(f_nc), .res(r_c)
	);

	// valid and degenerate flag ride alongside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				v_pipe_q[i] <= 1'b0;
			end
			done_q <= 1'b0;
		end else begin
			v_pipe_q[0] <= f_valid;
			for (int i = 1; i < DIV_LAT; i++) begin
				v_pipe_q[i] <= v_pipe_q[i-1];
			end
			done_q <= v_pipe_q[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		d_pipe_q[0] <= f_deg;
		for (int i = 1; i < DIV_LAT; i++) begin
			d_pipe_q[i] <= d_pipe_q[i-1];
		end
		deg_q <= d_pipe_q[DIV_LAT-1];
		wa_q <= d_pipe_q[DIV_LAT-1] ? '0 : r_a;
		wb_q <= d_pipe_q[DIV_LAT-1] ? '0 : r_b;
		wc_q <= d_pipe_q[DIV_LAT-1] ? '0 : r_c;
	end

	assign done = done_q;
	assign degenerate_flag = deg_q;
	assign weight_a = wa_q;
	assign weight_b = wb_q;
	assign weight_c = wc_q;

	`BTW_ASSERT(a_deg_zero, clk, arst_n, done && degenerate_flag |-> weight_a == 0 && weight_b == 0 && weight_c == 0)
	`BTW_ASSERT(a_front_to_done, clk, arst_n, f_valid |-> ##(DIV_LAT+1) done)
	`BTW_ASSERT(a_cfg_write, clk, arst_n, cfg_valid && cfg_ready |=> mode_q == $past(cfg_data))
	`BTW_NEVER(a_done_no_issue, clk, arst_n, done && !$past(v_pipe_q[DIV_LAT-1]))

endmodule
